FILE: hdl/pch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pch_pkg
// shared opcodes and widths for the posterized colour histogram
// ----------------------------------------------------------------------------
package pch_pkg;

  localparam int unsigned OpcodeWidth = 2;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 13;
  localparam int unsigned OutWeightWidth = 40;
  localparam int unsigned CountWidth = 13;

  // bucket hash folds by 2^10, which is 3 modulo this bucket count
  localparam int unsigned NumBuckets = 1021;
  localparam int unsigned BucketWidth = 10;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_MAX_COLORS     = 2'd0,
    CFG_IGNORE_BITS    = 2'd1,
    CFG_USE_IMPORTANCE = 2'd2,
    CFG_SPARE          = 2'd3
  } cfg_idx_t;

  function automatic logic [7:0] posterize(input logic [7:0] c, input logic [2:0] ib);
    logic [7:0] keep;
    logic [7:0] high;
    logic [15:0] hi_part;
    begin
      keep = 8'hFF << ib;
      high = ~(8'hFF >> ib);
      hi_part = {8'd0, c & high} >> (4'd8 - {1'b0, ib});
      posterize = (c & keep) | hi_part[7:0];
    end
  endfunction

endpackage : pch_pkg
`default_nettype wire

FILE: hdl/pch_bucket_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pch_bucket_hash
// colour modulo bucket count by folding, pipelined through registered folds
// ----------------------------------------------------------------------------
module pch_bucket_hash
  import pch_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [31:0]            color,
  output logic                        done,
  output logic [BucketWidth-1:0]      bucket
);

  logic [23:0] fold1;
  logic [23:0] fold1_q;
  logic [15:0] fold2;
  logic [15:0] fold2_q;
  logic [10:0] fold3;
  logic        v1;
  logic        v2;

  // x = hi * 1024 + lo folds to hi * 3 + lo
  assign fold1 = 24'({color[31:10], 1'b0}) + 24'(color[31:10]) + 24'(color[9:0]);
  assign fold2 = 16'({fold1_q[23:10], 1'b0}) + 16'(fold1_q[23:10]) + 16'(fold1_q[9:0]);
  assign fold3 = 11'({fold2_q[15:10], 1'b0}) + 11'(fold2_q[15:10]) + 11'(fold2_q[9:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      done <= v2;
    end
    fold1_q <= fold1;
    fold2_q <= fold2;
    if (fold3 >= 11'(NumBuckets)) begin
      bucket <= BucketWidth'(fold3 - 11'(NumBuckets));
    end else begin
      bucket <= fold3[BucketWidth-1:0];
    end
  end

endmodule : pch_bucket_hash
`default_nettype wire

FILE: hdl/posterized_color_histogram_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// posterized_color_histogram_core
// hashed colour histogram with chained buckets held in block memories
// ----------------------------------------------------------------------------
//  channel  signals                                    direction
//  in       valid/stall, opcode, red..alpha, importance  into block
//  out      out_valid/out_stall, out_red..overflow      out of block
//  cfg      cfg_we, cfg_idx, cfg_data                  into block
//
//  add: hash, head read, then an entry read and compare per chain entry, then
//  update or insert; read: one entry read; clear, read past end, unused
//  opcode and add after overflow go straight to the result.
//  bucket heads carry an epoch mark; reset and every 255th clear wipe all
//  1021 heads with the input stalled.
//  input is stalled while an item is in progress and while a result waits.
// ----------------------------------------------------------------------------
module posterized_color_histogram_core
  import pch_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 4096,
  parameter int unsigned WEIGHT_BITS = 40
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    valid,
  output logic                         stall,
  input  wire logic [1:0]              opcode,
  input  wire logic [7:0]              red,
  input  wire logic [7:0]              green,
  input  wire logic [7:0]              blue,
  input  wire logic [7:0]              alpha,
  input  wire logic [7:0]              importance,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic [7:0]                   out_alpha,
  output logic [OutWeightWidth-1:0]    weight,
  output logic [CountWidth-1:0]        color_count,
  output logic                         entry_valid,
  output logic                         last_entry,
  output logic                         overflow,
  input  wire logic                    cfg_we,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx,
  input  wire logic [CfgDataWidth-1:0] cfg_data
);

  localparam int unsigned EW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = EW + 1;
  localparam int unsigned LW = (CW > 13) ? CW : 13;
  localparam int unsigned BW = BucketWidth;
  localparam int unsigned EPW = 8;
  localparam logic [EPW-1:0] EP_LAST = '1;
  localparam logic [WEIGHT_BITS-1:0] WMAX = '1;
  localparam logic [CW-1:0] MAXE = CW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_HEAD, S_RDWAIT, S_CMP, S_UPD, S_INS, S_READ, S_EMIT, S_WIPE
  } state_t;

  state_t state;

  logic [12:0] max_colors;
  logic [2:0]  ignore_bits;
  logic        use_importance;

  logic [31:0]             color;
  logic [8:0]              boost;
  logic [CW-1:0]           count;
  logic [CW-1:0]           rptr;
  logic                    ovf;
  logic [EW-1:0]           idx;
  logic [BW-1:0]           bkt;
  logic [EPW-1:0]          epoch;
  logic [BW-1:0]           wipe_idx;
  logic                    wipe_emit;
  logic [EPW+EW-1:0]       head_q;
  logic                    head_live;

  logic [31:0]             mem_color [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0]  mem_weight [MAX_ENTRIES];
  logic [EW:0]             mem_next [MAX_ENTRIES];
  logic [EPW+EW-1:0]       mem_head [NumBuckets];

  logic [31:0]            rd_color;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [EW:0]            rd_next;
  logic [EW-1:0]          rd_addr;
  logic                   wr_en;
  logic [EW-1:0]          wr_addr;
  logic [31:0]            wr_color;
  logic [WEIGHT_BITS-1:0] wr_weight;
  logic [EW:0]            wr_next;
  logic                   head_we;
  logic [BW-1:0]          head_raddr;
  logic [BW-1:0]          head_waddr;
  logic [EPW+EW-1:0]      head_wdata;

  logic                   hash_go;
  logic                   hash_done;
  logic [BW-1:0]          hash_bucket;
  logic [31:0]            pcolor;
  logic [WEIGHT_BITS:0]   wsum;
  logic [CW-1:0]          limit;
  logic                   accept;

  assign accept = valid && !stall;
  assign stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    if (alpha == 8'd0) begin
      pcolor = '0;
    end else begin
      pcolor = {posterize(alpha, ignore_bits), posterize(blue, ignore_bits),
                posterize(green, ignore_bits), posterize(red, ignore_bits)};
    end
  end

  assign wsum = {1'b0, rd_weight} + (WEIGHT_BITS+1)'(boost);
  assign limit = (LW'(max_colors) < LW'(MAX_ENTRIES)) ? CW'(max_colors) : MAXE;
  assign head_live = (head_q[EPW+EW-1:EW] == epoch);

  pch_bucket_hash u_hash (
    .clk(clk), .rst(rst), .start(hash_go), .color(color),
    .done(hash_done), .bucket(hash_bucket)
  );

  always_ff @(posedge clk) begin
    rd_color <= mem_color[rd_addr];
    rd_weight <= mem_weight[rd_addr];
    rd_next <= mem_next[rd_addr];
    if (wr_en) begin
      mem_color[wr_addr] <= wr_color;
      mem_weight[wr_addr] <= wr_weight;
      mem_next[wr_addr] <= wr_next;
    end
  end

  always_ff @(posedge clk) begin
    head_q <= mem_head[head_raddr];
    if (head_we) begin
      mem_head[head_waddr] <= head_wdata;
    end
  end

  always_comb begin
    rd_addr = (state == S_IDLE) ? rptr[EW-1:0] : idx;
    wr_en = 1'b0;
    wr_addr = idx;
    wr_color = color;
    wr_weight = rd_weight;
    wr_next = '0;
    head_we = 1'b0;
    head_raddr = (state == S_HASH) ? hash_bucket : bkt;
    head_waddr = bkt;
    head_wdata = {epoch, count[EW-1:0]};
    if (state == S_UPD) begin
      wr_en = 1'b1;
      wr_weight = wsum[WEIGHT_BITS] ? WMAX : wsum[WEIGHT_BITS-1:0];
    end else if (state == S_INS && count < limit) begin
      wr_en = 1'b1;
      wr_addr = count[EW-1:0];
      wr_weight = (WEIGHT_BITS+1)'(boost) > {1'b0, WMAX} ? WMAX : WEIGHT_BITS'(boost);
      wr_next = {head_live, head_q[EW-1:0]};
      head_we = 1'b1;
    end else if (state == S_WIPE) begin
      head_we = 1'b1;
      head_waddr = wipe_idx;
      head_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_go <= 1'b0;
    end else begin
      hash_go <= accept && (opcode == OP_ADD) && !ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_colors <= 13'd4096;
      ignore_bits <= 3'd0;
      use_importance <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MAX_COLORS:     max_colors <= cfg_data;
        CFG_IGNORE_BITS:    ignore_bits <= cfg_data[2:0];
        CFG_USE_IMPORTANCE: use_importance <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      out_valid <= 1'b0;
      count <= '0;
      rptr <= '0;
      ovf <= 1'b0;
      epoch <= EPW'(1);
      wipe_idx <= '0;
      wipe_emit <= 1'b0;
    end else begin
      if (state == S_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            color <= pcolor;
            boost <= use_importance ? 9'd128 + {1'b0, importance} : 9'd256;
            out_red <= '0; out_green <= '0; out_blue <= '0; out_alpha <= '0;
            weight <= '0;
            entry_valid <= 1'b0;
            last_entry <= 1'b0;
            unique case (opcode_t'(opcode))
              OP_CLEAR: begin
                count <= '0;
                rptr <= '0;
                ovf <= 1'b0;
                if (epoch == EP_LAST) begin
                  epoch <= EPW'(1);
                  wipe_idx <= '0;
                  wipe_emit <= 1'b1;
                  state <= S_WIPE;
                end else begin
                  epoch <= epoch + 1'b1;
                  state <= S_EMIT;
                end
              end
              OP_ADD: begin
                {out_alpha, out_blue, out_green, out_red} <= pcolor;
                state <= ovf ? S_EMIT : S_HASH;
              end
              OP_READ: begin
                idx <= rptr[EW-1:0];
                state <= (rptr < count && rptr < MAXE) ? S_READ : S_EMIT;
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bkt <= hash_bucket;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (head_live) begin
            idx <= head_q[EW-1:0];
            state <= S_RDWAIT;
          end else begin
            state <= S_INS;
          end
        end
        S_RDWAIT: state <= S_CMP;
        S_CMP: begin
          if (rd_color == color) begin
            state <= S_UPD;
          end else if (rd_next[EW]) begin
            idx <= rd_next[EW-1:0];
            state <= S_RDWAIT;
          end else begin
            state <= S_INS;
          end
        end
        S_UPD: begin
          weight <= OutWeightWidth'(wsum[WEIGHT_BITS] ? WMAX : wsum[WEIGHT_BITS-1:0]);
          state <= S_EMIT;
        end
        S_INS: begin
          if (count < limit) begin
            count <= count + 1'b1;
            weight <= OutWeightWidth'(wr_weight);
          end else begin
            ovf <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_READ: begin
          {out_alpha, out_blue, out_green, out_red} <= rd_color;
          weight <= OutWeightWidth'(rd_weight);
          entry_valid <= 1'b1;
          last_entry <= (rptr + 1'b1 == count);
          rptr <= rptr + 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          state <= S_IDLE;
        end
        S_WIPE: begin
          if (wipe_idx == BW'(NumBuckets - 1)) begin
            state <= wipe_emit ? S_EMIT : S_IDLE;
          end else begin
            wipe_idx <= wipe_idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign color_count = CountWidth'(count);
  assign overflow = ovf;

  // hash starts in the cycle after the add is taken, from the registered colour
  pch_bucket_hash_kick: assert property (@(posedge clk) disable iff (rst)
    hash_go |-> state == S_HASH)
    else $error("hash kicked outside hash state");

  assert property (@(posedge clk) disable iff (rst)
    count <= MAXE)
    else $error("count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    rptr <= count)
    else $error("read pointer past count");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && count >= limit) |=> ovf)
    else $error("overflow not flagged");

endmodule : posterized_color_histogram_core
`default_nettype wire

FILE: tb/sv/posterized_color_histogram_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posterized_color_histogram_checker
// Watches the item, result and configuration ports of the colour histogram.
// Keeps its own copy of the table, predicts the result of every item that is
// taken and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module posterized_color_histogram_checker
  import pch_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic [7:0]  importance,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  input  logic [39:0] weight,
  input  logic [12:0] color_count,
  input  logic        entry_valid,
  input  logic        last_entry,
  input  logic        overflow,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [12:0] cfg_data,
  output int          failures,
  output int          pending
);

  localparam int TableSize = 4096;
  localparam int BucketCount = 1021;
  localparam logic [39:0] WeightMax = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] color;
    logic [39:0] wt;
    logic [12:0] count;
    logic        hit;
    logic        last;
    logic        ovf;
  } hist_result_t;

  logic [31:0] tbl_color [TableSize];
  logic [39:0] tbl_weight [TableSize];
  int          tbl_next [TableSize];
  int          chain_head [BucketCount];
  int          n_colors;
  int          read_idx;
  logic        ovf_flag;
  logic [12:0] lim_colors;
  logic [2:0]  drop_bits;
  logic        imp_mode;

  hist_result_t expected_results [$];

  function automatic logic [7:0] quantise(input logic [7:0] c);
    logic [7:0] keep;
    keep = 8'hFF << drop_bits;
    return (c & keep) | (c >> (8 - drop_bits));
  endfunction

  function automatic void empty_table();
    foreach (chain_head[i]) chain_head[i] = -1;
    n_colors = 0;
    read_idx = 0;
    ovf_flag = 1'b0;
  endfunction

  function automatic hist_result_t histogram_step(input opcode_t op, input logic [7:0] r,
                                                  input logic [7:0] g, input logic [7:0] b,
                                                  input logic [7:0] a, input logic [7:0] imp);
    hist_result_t res;
    logic [39:0] boost;
    int bkt;
    int idx;
    int limit;
    res = '0;
    case (op)
      OP_CLEAR: empty_table();
      OP_ADD: begin
        if (a != 0) res.color = {quantise(a), quantise(b), quantise(g), quantise(r)};
        if (!ovf_flag) begin
          boost = imp_mode ? 40'd128 + imp : 40'd256;
          bkt = res.color % BucketCount;
          idx = chain_head[bkt];
          while (idx >= 0 && tbl_color[idx] != res.color) idx = tbl_next[idx];
          if (idx >= 0) begin
            tbl_weight[idx] = (tbl_weight[idx] > WeightMax - boost) ? WeightMax
                                                                    : tbl_weight[idx] + boost;
            res.wt = tbl_weight[idx];
          end else begin
            limit = (lim_colors < TableSize) ? lim_colors : TableSize;
            if (n_colors >= limit) begin
              ovf_flag = 1'b1;
            end else begin
              tbl_color[n_colors] = res.color;
              tbl_weight[n_colors] = boost;
              tbl_next[n_colors] = chain_head[bkt];
              chain_head[bkt] = n_colors;
              n_colors++;
              res.wt = boost;
            end
          end
        end
      end
      OP_READ: begin
        if (read_idx < n_colors) begin
          res.color = tbl_color[read_idx];
          res.wt = tbl_weight[read_idx];
          res.hit = 1'b1;
          res.last = (read_idx + 1 == n_colors);
          read_idx++;
        end
      end
      default: ;
    endcase
    res.count = n_colors[12:0];
    res.ovf = ovf_flag;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [39:0] exp_v,
                             input logic [39:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  initial begin
    failures = 0;
    empty_table();
    lim_colors = 13'd4096;
    drop_bits = 3'd0;
    imp_mode = 1'b0;
  end

  assign pending = expected_results.size();

  always @(posedge clk) begin
    hist_result_t exp_r;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_MAX_COLORS:     lim_colors = cfg_data;
          CFG_IGNORE_BITS:    drop_bits = cfg_data[2:0];
          CFG_USE_IMPORTANCE: imp_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (valid && !stall)
        expected_results.push_back(histogram_step(opcode_t'(opcode), red, green, blue,
                                                  alpha, importance));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          failures++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("out_red", 40'(exp_r.color[7:0]), 40'(out_red));
          check_field("out_green", 40'(exp_r.color[15:8]), 40'(out_green));
          check_field("out_blue", 40'(exp_r.color[23:16]), 40'(out_blue));
          check_field("out_alpha", 40'(exp_r.color[31:24]), 40'(out_alpha));
          check_field("weight", exp_r.wt, weight);
          check_field("color_count", 40'(exp_r.count), 40'(color_count));
          check_field("entry_valid", 40'(exp_r.hit), 40'(entry_valid));
          check_field("last_entry", 40'(exp_r.last), 40'(last_entry));
          check_field("overflow", 40'(exp_r.ovf), 40'(overflow));
        end
      end
    end
  end

endmodule

FILE: tb/sv/posterized_color_histogram_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posterized_color_histogram_core_test
// Drives directed and random clear, add, read and unused-opcode items into the colour
// histogram under several register settings and idling patterns, with one
// long output hold-off; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module posterized_color_histogram_core_test;
  import pch_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [1:0]  opcode = OP_NONE;
  logic [7:0]  red = '0, green = '0, blue = '0, alpha = '0, importance = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic [39:0] weight;
  logic [12:0] color_count;
  logic        entry_valid, last_entry, overflow;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_MAX_COLORS;
  logic [12:0] cfg_data = '0;
  int          failures, pending;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;

  always #10 clk = ~clk;

  posterized_color_histogram_core i_dut (.*);

  posterized_color_histogram_checker i_checker (.*);

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (400) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    #60ms;
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input opcode_t op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a, input logic [7:0] imp);
    while ($urandom_range(99) < tx_idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    opcode <= op;
    red <= r;
    green <= g;
    blue <= b;
    alpha <= a;
    importance <= imp;
    do @(posedge clk); while (stall);
  endtask

  task automatic drain();
    valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_config(input logic [12:0] lim, input logic [2:0] ib, input logic imp);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MAX_COLORS;
    cfg_data <= lim;
    @(posedge clk);
    cfg_idx <= CFG_IGNORE_BITS;
    cfg_data <= {10'd0, ib};
    @(posedge clk);
    cfg_idx <= CFG_USE_IMPORTANCE;
    cfg_data <= {12'd0, imp};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(input int count, input int palette);
    int sel;
    logic [7:0] r, g, b, a;
    repeat (count) begin
      sel = $urandom_range(99);
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); a = 8'($urandom);
      if ($urandom_range(99) < palette) begin
        r = {2'($urandom_range(3)), 6'd0} | {6'd0, r[1:0]};
        g = {1'($urandom_range(1)), 7'd0};
        b = {1'($urandom_range(1)), 7'd0} | {7'd0, b[0]};
        a = $urandom_range(1) ? 8'hFF : 8'h80;
      end
      if ($urandom_range(99) < 8) a = 8'h00;
      if (sel < 2) send_item(OP_CLEAR, r, g, b, a, 8'($urandom));
      else if (sel < 62) send_item(OP_ADD, r, g, b, a, 8'($urandom));
      else if (sel < 96) send_item(OP_READ, r, g, b, a, 8'($urandom));
      else send_item(OP_NONE, r, g, b, a, 8'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, transparent pixel, read past end, unused opcode
    send_item(OP_ADD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_item(OP_ADD, 8'h12, 8'h34, 8'h56, 8'h01, 8'h00);
    send_item(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    repeat (4) send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();
    // one colour allowed, importance boost, widest posterizing, alpha lost
    set_config(13'd1, 3'd7, 1'b1);
    send_item(OP_ADD, 8'h80, 8'h7F, 8'h01, 8'h7F, 8'hFF);
    send_item(OP_ADD, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00);
    send_item(OP_ADD, 8'h00, 8'h00, 8'h00, 8'h40, 8'h10);
    send_item(OP_ADD, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();
    // zero limit: every new colour overflows
    set_config(13'd0, 3'd4, 1'b0);
    send_item(OP_ADD, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h00);
    send_item(OP_ADD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();

    tx_idle_pct = 26;
    rx_idle_pct = 78;
    set_config(13'd8191, 3'd0, 1'b0);
    random_items(250, 70);
    drain();
    set_config(13'd20, 3'd5, 1'b1);
    random_items(250, 60);
    drain();

    tx_idle_pct = 78;
    rx_idle_pct = 26;
    set_config(13'd4096, 3'd3, 1'b1);
    random_items(250, 50);
    drain();
    set_config(13'd3, 3'd6, 1'b0);
    random_items(250, 40);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(13'd64, 3'd2, 1'b0);
    hold_req = 1'b1;
    random_items(250, 50);
    drain();
    set_config(13'd1, 3'd1, 1'b1);
    random_items(250, 80);
    drain();

    if (failures == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: posterized_color_histogram_core.f
hdl/pch_pkg.sv
hdl/pch_bucket_hash.sv
hdl/posterized_color_histogram_core.sv
tb/sv/posterized_color_histogram_checker.sv
tb/sv/posterized_color_histogram_core_test.sv
